/* hw/rtl/lc3_instruction_execute_macros.svh */
// Assertion macros for the LC-3 executor checker.
// Used by lc3x_chk; expects clk and arst_n in scope.
`ifndef LC3_INSTRUCTION_EXECUTE_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTE_MACROS_SVH

// same-cycle implication
`define LC3X_IMPLY(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("lc3x check failed");

// next-cycle implication
`define LC3X_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("lc3x check failed");

`endif

/* hw/rtl/lc3_pkg.sv */
// Shared types, codes and helpers for the LC-3 executor.
// No dependencies.
`default_nettype none
package lc3_pkg;
	localparam int ADDR_BITS_DEF = 16;
	localparam int MAX_CHARS_DEF = 64;
	localparam logic [15:0] RESET_PC = 16'h3000;

	localparam logic [2:0] CC_N = 3'd4;
	localparam logic [2:0] CC_Z = 3'd2;
	localparam logic [2:0] CC_P = 3'd1;

	localparam logic [7:0] VEC_GETC  = 8'h20;
	localparam logic [7:0] VEC_OUT   = 8'h21;
	localparam logic [7:0] VEC_PUTS  = 8'h22;
	localparam logic [7:0] VEC_IN    = 8'h23;
	localparam logic [7:0] VEC_PUTSP = 8'h24;
	localparam logic [7:0] VEC_HALT  = 8'h25;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_EXEC  = 2'd1,
		CMD_SETPC = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		OP_BR = 4'd0, OP_ADD = 4'd1, OP_LD = 4'd2, OP_ST = 4'd3,
		OP_JSR = 4'd4, OP_AND = 4'd5, OP_LDR = 4'd6, OP_STR = 4'd7,
		OP_RTI = 4'd8, OP_NOT = 4'd9, OP_LDI = 4'd10, OP_STI = 4'd11,
		OP_JMP = 4'd12, OP_RES = 4'd13, OP_LEA = 4'd14, OP_TRAP = 4'd15
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXEC, ST_OP, ST_RD1, ST_RD2, ST_SCAN, ST_HI, ST_PREP, ST_SEND
	} state_t;

	typedef struct packed {
		logic        en;
		logic        we;
		logic [15:0] addr;
		logic [15:0] wdata;
	} mem_req_t;

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		if (v == 16'd0)
			return CC_Z;
		else if (v[15])
			return CC_N;
		else
			return CC_P;
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/lc3x_wmem.sv */
// Single-port word memory, 2^ADDR_BITS x 16, registered read.
// Depends on lc3_pkg (mem_req_t).
`default_nettype none
module lc3x_wmem #(
	parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEF
) (
	input  wire logic              clk,
	input  wire lc3_pkg::mem_req_t req,
	output logic [15:0]            rdata
);
	logic [15:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we)
				mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
			else
				rdata <= mem[req.addr[ADDR_BITS-1:0]];
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/lc3x_cbuf.sv */
// Character buffer for one step's console output, registered read.
// No package dependencies.
`default_nettype none
module lc3x_cbuf #(
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [7:0]               wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]                    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/lc3_instruction_execute.sv */
// LC-3 executor top: sequencer, register file, shared adder, memories.
// Depends on lc3_pkg, lc3x_wmem, lc3x_cbuf.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser command, tdata address/data/instruction/key_char
// m_*      out  m_tvalid/m_tready  tuser char_valid, tlast last, tdata status+char
//
// Ready only in idle. From accept to the first valid result item the sequencer steps through
// EXEC and PREP; CMD_EXEC adds OP, LD/LDR/STI/LDI add RD1 and LDI also RD2 (single memory port).
// PUTS/PUTSP: scan characters into the buffer, then one item per cycle while m_tready is high.
// Result items hold under m_tready low. Reset: R0-R7 zero, PC 0x3000, CC set to Z.
`default_nettype none
module lc3_instruction_execute #(
	parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEF,
	parameter int MAX_CHARS = lc3_pkg::MAX_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // address, data, instruction, key_char
	input  wire logic [1:0]  s_tuser,  // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // char_out, halted, illegal, truncated, pc_now, cond_flags
	output logic             m_tuser,  // char_valid
	output logic             m_tlast
);
	localparam int IW = $clog2(MAX_CHARS);
	localparam int CW = $clog2(MAX_CHARS + 1);

	lc3_pkg::state_t   state_q, state_d;
	lc3_pkg::cmd_t     cmd_q;
	lc3_pkg::mem_req_t mreq;
	logic [15:0] addr_q, data_q, ins_q;
	logic [7:0]  key_q;
	logic [15:0] rf_q [8];
	logic [15:0] pc_q;
	logic [2:0]  cc_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic halt_q, bad_q, trunc_q;
	logic [ADDR_BITS-1:0] sptr_q;
	logic [15:0] word_q;

	logic [15:0] add_a, add_b, sum, mem_rdata;
	logic [15:0] off9, off6, off11, opnd, rsrc, kext;
	logic [2:0]  dr, sr1;
	logic        cb_we, cb_re, packed_w, last_w, at_cap;
	logic [IW-1:0] cb_waddr, cb_raddr;
	logic [7:0]  cb_wdata, cb_rdata;
	lc3_pkg::op_t op;

	assign op    = lc3_pkg::op_t'(ins_q[15:12]);
	assign dr    = ins_q[11:9];
	assign sr1   = ins_q[8:6];
	assign off9  = {{7{ins_q[8]}}, ins_q[8:0]};
	assign off6  = {{10{ins_q[5]}}, ins_q[5:0]};
	assign off11 = {{5{ins_q[10]}}, ins_q[10:0]};
	assign rsrc  = rf_q[sr1];
	assign opnd  = ins_q[5] ? {{11{ins_q[4]}}, ins_q[4:0]} : rf_q[ins_q[2:0]];
	assign kext  = {{8{key_q[7]}}, key_q};
	assign sum   = add_a + add_b;
	assign packed_w = (ins_q[7:0] == lc3_pkg::VEC_PUTSP);
	assign at_cap   = (cnt_q == CW'(MAX_CHARS));
	assign last_w   = (cnt_q == '0) || ((idx_q + CW'(1)) == cnt_q);

	lc3x_wmem #(.ADDR_BITS(ADDR_BITS)) u_wmem (.clk(clk), .req(mreq), .rdata(mem_rdata));

	lc3x_cbuf #(.DEPTH(MAX_CHARS)) u_cbuf (
		.clk(clk), .we(cb_we), .waddr(cb_waddr), .wdata(cb_wdata),
		.re(cb_re), .raddr(cb_raddr), .rdata(cb_rdata)
	);

	always_comb begin
		state_d  = state_q;
		mreq     = '0;
		add_a    = pc_q;
		add_b    = 16'd1;
		cb_we    = 1'b0;
		cb_waddr = cnt_q[IW-1:0];
		cb_wdata = mem_rdata[7:0];
		cb_re    = 1'b0;
		cb_raddr = idx_q[IW-1:0];
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			lc3_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = lc3_pkg::ST_EXEC;
			end
			lc3_pkg::ST_EXEC: begin
				if (cmd_q == lc3_pkg::CMD_WRITE) begin
					mreq.en    = 1'b1;
					mreq.we    = 1'b1;
					mreq.addr  = addr_q;
					mreq.wdata = data_q;
				end
				state_d = (cmd_q == lc3_pkg::CMD_EXEC) ? lc3_pkg::ST_OP : lc3_pkg::ST_PREP;
			end
			lc3_pkg::ST_OP: begin
				state_d = lc3_pkg::ST_PREP;
				unique case (op)
					lc3_pkg::OP_ADD: begin
						add_a = rsrc;
						add_b = opnd;
					end
					lc3_pkg::OP_BR, lc3_pkg::OP_LEA, lc3_pkg::OP_ST: begin
						add_b = off9;
						if (op == lc3_pkg::OP_ST) begin
							mreq.en    = 1'b1;
							mreq.we    = 1'b1;
							mreq.addr  = sum;
							mreq.wdata = rf_q[dr];
						end
					end
					lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_STI: begin
						add_b     = off9;
						mreq.en   = 1'b1;
						mreq.addr = sum;
						state_d   = lc3_pkg::ST_RD1;
					end
					lc3_pkg::OP_LDR: begin
						add_a     = rsrc;
						add_b     = off6;
						mreq.en   = 1'b1;
						mreq.addr = sum;
						state_d   = lc3_pkg::ST_RD1;
					end
					lc3_pkg::OP_STR: begin
						add_a      = rsrc;
						add_b      = off6;
						mreq.en    = 1'b1;
						mreq.we    = 1'b1;
						mreq.addr  = sum;
						mreq.wdata = rf_q[dr];
					end
					lc3_pkg::OP_JSR: add_b = off11;
					lc3_pkg::OP_TRAP: begin
						cb_waddr = '0;
						if (ins_q[7:0] == lc3_pkg::VEC_OUT) begin
							cb_we    = 1'b1;
							cb_wdata = rf_q[0][7:0];
						end else if (ins_q[7:0] == lc3_pkg::VEC_IN) begin
							cb_we    = 1'b1;
							cb_wdata = key_q;
						end else if (ins_q[7:0] == lc3_pkg::VEC_PUTS || packed_w) begin
							mreq.en   = 1'b1;
							mreq.addr = rf_q[0];
							state_d   = lc3_pkg::ST_SCAN;
						end
					end
					default: ;
				endcase
			end
			lc3_pkg::ST_RD1: begin
				state_d = lc3_pkg::ST_PREP;
				if (op == lc3_pkg::OP_LDI) begin
					mreq.en   = 1'b1;
					mreq.addr = mem_rdata;
					state_d   = lc3_pkg::ST_RD2;
				end else if (op == lc3_pkg::OP_STI) begin
					mreq.en    = 1'b1;
					mreq.we    = 1'b1;
					mreq.addr  = mem_rdata;
					mreq.wdata = rf_q[dr];
				end
			end
			lc3_pkg::ST_RD2: state_d = lc3_pkg::ST_PREP;
			lc3_pkg::ST_SCAN: begin
				add_a = 16'(sptr_q);
				if (mem_rdata == 16'd0 || at_cap) begin
					state_d = lc3_pkg::ST_PREP;
				end else begin
					cb_we = 1'b1;
					if (packed_w && mem_rdata[15:8] != 8'd0) begin
						state_d = lc3_pkg::ST_HI;
					end else begin
						mreq.en   = 1'b1;
						mreq.addr = sum;
					end
				end
			end
			lc3_pkg::ST_HI: begin
				add_a    = 16'(sptr_q);
				cb_wdata = word_q[15:8];
				if (at_cap) begin
					state_d = lc3_pkg::ST_PREP;
				end else begin
					cb_we     = 1'b1;
					mreq.en   = 1'b1;
					mreq.addr = sum;
					state_d   = lc3_pkg::ST_SCAN;
				end
			end
			lc3_pkg::ST_PREP: begin
				cb_re    = 1'b1;
				cb_raddr = '0;
				state_d  = lc3_pkg::ST_SEND;
			end
			lc3_pkg::ST_SEND: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (last_w) begin
						state_d = lc3_pkg::ST_IDLE;
					end else begin
						cb_re    = 1'b1;
						cb_raddr = IW'(idx_q + CW'(1));
					end
				end
			end
			default: state_d = lc3_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lc3_pkg::ST_IDLE;
			for (int i = 0; i < 8; i++)
				rf_q[i] <= 16'd0;
			pc_q    <= lc3_pkg::RESET_PC;
			cc_q    <= lc3_pkg::CC_Z;
			cnt_q   <= '0;
			idx_q   <= '0;
			halt_q  <= 1'b0;
			bad_q   <= 1'b0;
			trunc_q <= 1'b0;
			sptr_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lc3_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= '0;
						halt_q  <= 1'b0;
						bad_q   <= 1'b0;
						trunc_q <= 1'b0;
					end
				end
				lc3_pkg::ST_EXEC: begin
					if (cmd_q == lc3_pkg::CMD_SETPC)
						pc_q <= data_q;
					else if (cmd_q == lc3_pkg::CMD_EXEC)
						pc_q <= sum;
				end
				lc3_pkg::ST_OP: begin
					sptr_q <= rf_q[0][ADDR_BITS-1:0];
					unique case (op)
						lc3_pkg::OP_ADD, lc3_pkg::OP_LEA: begin
							rf_q[dr] <= sum;
							cc_q     <= lc3_pkg::cc_of(sum);
						end
						lc3_pkg::OP_AND: begin
							rf_q[dr] <= rsrc & opnd;
							cc_q     <= lc3_pkg::cc_of(rsrc & opnd);
						end
						lc3_pkg::OP_NOT: begin
							rf_q[dr] <= ~rsrc;
							cc_q     <= lc3_pkg::cc_of(~rsrc);
						end
						lc3_pkg::OP_BR: begin
							if ((ins_q[11:9] & cc_q) != 3'd0)
								pc_q <= sum;
						end
						lc3_pkg::OP_JMP: pc_q <= rsrc;
						lc3_pkg::OP_JSR: begin
							rf_q[7] <= pc_q;
							pc_q    <= ins_q[11] ? sum : rsrc;
						end
						lc3_pkg::OP_TRAP: begin
							rf_q[7] <= pc_q;
							if (ins_q[7:0] == lc3_pkg::VEC_GETC)
								rf_q[0] <= kext;
							else if (ins_q[7:0] == lc3_pkg::VEC_IN) begin
								rf_q[0] <= kext;
								cnt_q   <= CW'(1);
							end else if (ins_q[7:0] == lc3_pkg::VEC_OUT)
								cnt_q <= CW'(1);
							else if (ins_q[7:0] == lc3_pkg::VEC_HALT)
								halt_q <= 1'b1;
						end
						lc3_pkg::OP_RTI, lc3_pkg::OP_RES: begin
							halt_q <= 1'b1;
							bad_q  <= 1'b1;
						end
						default: ;
					endcase
				end
				lc3_pkg::ST_RD1: begin
					if (op == lc3_pkg::OP_LD || op == lc3_pkg::OP_LDR) begin
						rf_q[dr] <= mem_rdata;
						cc_q     <= lc3_pkg::cc_of(mem_rdata);
					end
				end
				lc3_pkg::ST_RD2: begin
					rf_q[dr] <= mem_rdata;
					cc_q     <= lc3_pkg::cc_of(mem_rdata);
				end
				lc3_pkg::ST_SCAN: begin
					if (mem_rdata != 16'd0) begin
						if (at_cap)
							trunc_q <= 1'b1;
						else begin
							cnt_q <= cnt_q + CW'(1);
							if (!(packed_w && mem_rdata[15:8] != 8'd0))
								sptr_q <= sum[ADDR_BITS-1:0];
						end
					end
				end
				lc3_pkg::ST_HI: begin
					if (at_cap)
						trunc_q <= 1'b1;
					else begin
						cnt_q  <= cnt_q + CW'(1);
						sptr_q <= sum[ADDR_BITS-1:0];
					end
				end
				lc3_pkg::ST_PREP: idx_q <= '0;
				lc3_pkg::ST_SEND: begin
					if (m_tready && !last_w)
						idx_q <= idx_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// payload latches
	always_ff @(posedge clk) begin
		if (state_q == lc3_pkg::ST_IDLE && s_tvalid) begin
			cmd_q  <= lc3_pkg::cmd_t'(s_tuser);
			addr_q <= s_tdata[15:0];
			data_q <= s_tdata[31:16];
			ins_q  <= s_tdata[47:32];
			key_q  <= s_tdata[55:48];
		end
		if (state_q == lc3_pkg::ST_SCAN)
			word_q <= mem_rdata;
	end

	assign m_tuser = (cnt_q != '0);
	assign m_tlast = last_w;
	assign m_tdata = {2'b00, cc_q, pc_q, trunc_q, bad_q, halt_q,
		(cnt_q != '0) ? cb_rdata : 8'd0};
endmodule
`default_nettype wire

/* hw/rtl/lc3x_chk.sv */
// Port-level checker for lc3_instruction_execute, with its bind.
// Depends on lc3_instruction_execute_macros.svh.
`default_nettype none
`include "lc3_instruction_execute_macros.svh"
module lc3x_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);
	`LC3X_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`LC3X_IMPLY(a_no_input_while_out, m_tvalid, !s_tready)
	`LC3X_IMPLY(a_nochar_is_last, m_tvalid && !m_tuser, m_tlast)
	`LC3X_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind lc3_instruction_execute lc3x_chk u_chk (.*);
`default_nettype wire
